/* hw/rtl/scs_pkg.sv */
// Package for the scan change score unit: payload types, widths and constants.
package scs_pkg;

	localparam int unsigned MAX_DEVICES_DEF = 32;
	localparam int unsigned ID_W = 48;
	localparam int unsigned LVL_W = 8;
	localparam int unsigned SCORE_W = 16;
	localparam int unsigned DCNT_W = 6;
	localparam int unsigned Q_W = 17;
	localparam int unsigned NUM_W = 48;
	localparam int unsigned DEN_W = 24;
	localparam int unsigned MUL_W = 24;
	localparam int unsigned SUM_W = 17;
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned MS_SH = 3;
	localparam int unsigned RM_DIV = 12;
	localparam int unsigned W_CS = 35;
	localparam int unsigned W_RM = 30;
	// num / 100 as ((num >> 2) * RECIP_25) >> RECIP_SH, exact while num < 2**24
	localparam int unsigned DIV_PRE_SH = 2;
	localparam int unsigned RECIP_25 = 5368710;
	localparam int unsigned RECIP_SH = 27;
	localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;

	localparam logic ACT_RECORD = 1'b0;
	localparam logic ACT_END = 1'b1;

	typedef struct packed {
		logic action;
		logic [ID_W-1:0] device_id;
		logic signed [LVL_W-1:0] rssi;
	} in_item_t;

	typedef struct packed {
		logic [SCORE_W-1:0] change_score;
		logic [DCNT_W-1:0] device_count;
	} out_item_t;

	function automatic logic [Q_W-1:0] sat_one(input logic [NUM_W-1:0] q);
		logic [Q_W-1:0] r;
		r = (q > NUM_W'(ONE_Q16)) ? ONE_Q16 : q[Q_W-1:0];
		return r;
	endfunction

	function automatic logic [SCORE_W-1:0] sat_score(input logic [NUM_W-1:0] q);
		logic [SCORE_W-1:0] r;
		r = (q > NUM_W'({SCORE_W{1'b1}})) ? {SCORE_W{1'b1}} : q[SCORE_W-1:0];
		return r;
	endfunction

endpackage

/* hw/rtl/scan_change_score_unit.sv */
// Scan change score unit: stores scan records and scores each scan against the last.
//
// Input channel in_valid/in_stall carries in_item. A device record is taken and
// written to the current-scan bank of the record memory, unless the list
// already holds MAX_DEVICES records, then it is dropped. An end-of-scan transaction
// starts the scoring sequence; in_stall stays high until the result is loaded.
// Output channel out_valid/out_stall carries out_item from a result register, so
// records of the next scan are taken while a result waits for the receiver; a later
// end of scan holds in its last step until that register frees.
// Scoring runs on one shared 24x24 multiplier and one 48/24 restoring divider
// (48 iterations per divide) under a sequencer; the final divide by 100 is a
// reciprocal multiply. First scan or two empty scans score zero without a divide.
// Set mode adds to the count-and-mean steps a match scan, comparing each current
// record with the previous list until a match, plus up to two divides and five steps.
// The banks swap at the end of each scan, so no copy is needed.
// cfg_valid/cfg_ready writes use_set; cfg_ready is always high.
// Reset clears counts, the first-scan flag and sets use_set; record memory is not
// cleared since only written entries are read.
module scan_change_score_unit #(
	parameter int unsigned MAX_DEVICES = scs_pkg::MAX_DEVICES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input scs_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output scs_pkg::out_item_t out_item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_data
);

	localparam int unsigned CW = $clog2(MAX_DEVICES + 1);
	localparam int unsigned AW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
	localparam int unsigned MW = scs_pkg::ID_W + scs_pkg::LVL_W;
	localparam int unsigned MVW = CW + scs_pkg::LVL_W + 1;
	localparam int unsigned DCW = $clog2(scs_pkg::NUM_W + 1);
	localparam int unsigned PW = 2 * scs_pkg::MUL_W;

	typedef enum logic [16:0] {
		ST_IDLE = 17'h00001,
		ST_CC   = 17'h00002,
		ST_M1   = 17'h00004,
		ST_M2   = 17'h00008,
		ST_M3   = 17'h00010,
		ST_MS   = 17'h00020,
		ST_MI   = 17'h00040,
		ST_MCAP = 17'h00080,
		ST_MJ   = 17'h00100,
		ST_SC   = 17'h00200,
		ST_RMM  = 17'h00400,
		ST_RM   = 17'h00800,
		ST_N1   = 17'h01000,
		ST_N2   = 17'h02000,
		ST_FIN  = 17'h04000,
		ST_DQ   = 17'h08000,
		ST_OUT  = 17'h10000
	} state_t;

	state_t state_q;
	logic use_set_q, have_prev_q, bank_q;
	logic [CW-1:0] nc_q, np_q, i_q, j_q, match_q;
	logic signed [scs_pkg::SUM_W-1:0] sumc_q, sump_q;
	logic [MVW-1:0] mv_q;
	logic [MW-1:0] mem [2**(AW+1)];
	logic [MW-1:0] rdata_q;
	logic [AW:0] rd_addr;
	logic [scs_pkg::ID_W-1:0] cur_id_q;
	logic signed [scs_pkg::LVL_W-1:0] cur_lv_q;
	logic [scs_pkg::Q_W-1:0] cc_q, rm_q;
	logic signed [scs_pkg::FRAC_W+CW:0] sc_q;
	logic signed [PW-1:0] prod_q, t_q, diff_q, num_s;
	logic signed [scs_pkg::MUL_W-1:0] mul_a, mul_b;
	logic [scs_pkg::SCORE_W-1:0] score_q;
	logic out_valid_q;
	scs_pkg::out_item_t out_q;

	logic [scs_pkg::NUM_W-1:0] dq_q, dnum;
	logic [scs_pkg::DEN_W-1:0] dr_q, dd_q, dden;
	logic [DCW-1:0] dcnt_q;
	logic dbusy_q, ph_q, dstart, dfin;
	logic [scs_pkg::DEN_W+1:0] trial;

	logic in_acc, is_end, rec_wr, take_out;
	logic [CW-1:0] cdiff, cmax;
	logic [CW:0] u_s, scn;
	logic [PW-1:0] adiff;
	logic signed [scs_pkg::LVL_W:0] lvdiff;
	logic [scs_pkg::LVL_W:0] alv;
	logic id_eq, last_j;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign is_end = (in_item.action == scs_pkg::ACT_END);
	assign rec_wr = in_acc && !is_end && (nc_q < CW'(MAX_DEVICES));
	assign out_valid = out_valid_q;
	assign out_item = out_q;
	assign take_out = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	assign cdiff = (nc_q > np_q) ? (nc_q - np_q) : (np_q - nc_q);
	assign cmax = (nc_q > np_q) ? nc_q : np_q;
	assign u_s = {1'b0, nc_q} + {1'b0, np_q} - {1'b0, match_q};
	assign scn = ({1'b0, match_q} > u_s) ? ({1'b0, match_q} - u_s) : (u_s - {1'b0, match_q});
	assign adiff = diff_q[PW-1] ? PW'(-diff_q) : PW'(diff_q);
	assign num_s = t_q + prod_q;
	assign lvdiff = {cur_lv_q[scs_pkg::LVL_W-1], cur_lv_q}
		- {rdata_q[scs_pkg::LVL_W-1], rdata_q[scs_pkg::LVL_W-1:0]};
	assign alv = lvdiff[scs_pkg::LVL_W] ? (scs_pkg::LVL_W+1)'(-lvdiff)
		: (scs_pkg::LVL_W+1)'(lvdiff);
	assign id_eq = (cur_id_q == rdata_q[MW-1:scs_pkg::LVL_W]);
	assign last_j = ((j_q + CW'(1)) == np_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_M1: begin
				mul_a = scs_pkg::MUL_W'(sumc_q);
				mul_b = $signed(scs_pkg::MUL_W'(np_q == '0 ? CW'(1) : np_q));
			end
			ST_M2: begin
				mul_a = scs_pkg::MUL_W'(sump_q);
				mul_b = $signed(scs_pkg::MUL_W'(nc_q == '0 ? CW'(1) : nc_q));
			end
			ST_M3: begin
				mul_a = $signed(scs_pkg::MUL_W'(np_q == '0 ? CW'(1) : np_q));
				mul_b = $signed(scs_pkg::MUL_W'(nc_q == '0 ? CW'(1) : nc_q));
			end
			ST_RMM: begin
				mul_a = $signed(scs_pkg::MUL_W'(match_q));
				mul_b = scs_pkg::MUL_W'(scs_pkg::RM_DIV);
			end
			ST_N1: begin
				mul_a = scs_pkg::MUL_W'($signed({1'b0, cc_q}) + sc_q);
				mul_b = scs_pkg::MUL_W'(scs_pkg::W_CS);
			end
			ST_N2: begin
				mul_a = $signed(scs_pkg::MUL_W'(rm_q));
				mul_b = scs_pkg::MUL_W'(scs_pkg::W_RM);
			end
			ST_FIN: begin
				mul_a = scs_pkg::MUL_W'(num_s >>> scs_pkg::DIV_PRE_SH);
				mul_b = scs_pkg::MUL_W'(scs_pkg::RECIP_25);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		dstart = 1'b0;
		dnum = '0;
		dden = '0;
		case (state_q)
			ST_CC: begin
				dstart = !ph_q;
				dnum = scs_pkg::NUM_W'(cdiff) << scs_pkg::FRAC_W;
				dden = scs_pkg::DEN_W'(cmax);
			end
			ST_MS: begin
				dstart = !ph_q;
				dnum = {adiff[scs_pkg::NUM_W-scs_pkg::FRAC_W-1:0], scs_pkg::FRAC_W'(0)};
				dden = {prod_q[scs_pkg::DEN_W-scs_pkg::MS_SH-1:0], scs_pkg::MS_SH'(0)};
			end
			ST_SC: begin
				dstart = !ph_q;
				dnum = scs_pkg::NUM_W'(scn) << scs_pkg::FRAC_W;
				dden = scs_pkg::DEN_W'(u_s);
			end
			ST_RM: begin
				dstart = !ph_q && (match_q != '0);
				dnum = scs_pkg::NUM_W'(mv_q) << scs_pkg::FRAC_W;
				dden = prod_q[scs_pkg::DEN_W-1:0];
			end
			default: begin
				dstart = 1'b0;
			end
		endcase
	end

	assign dfin = ph_q && !dbusy_q;
	assign trial = {1'b0, dr_q, dq_q[scs_pkg::NUM_W-1]} - {2'b00, dd_q};

	always_comb begin
		rd_addr = '0;
		case (state_q)
			ST_MI: rd_addr = {~bank_q, i_q[AW-1:0]};
			ST_MCAP: rd_addr = {bank_q, AW'(0)};
			ST_MJ: rd_addr = {bank_q, AW'(j_q + CW'(1))};
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rec_wr) begin
			mem[{~bank_q, nc_q[AW-1:0]}] <= {in_item.device_id, in_item.rssi};
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			ph_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			if (dstart) begin
				ph_q <= 1'b1;
				dbusy_q <= 1'b1;
				dcnt_q <= DCW'(scs_pkg::NUM_W);
			end else if (dbusy_q) begin
				dcnt_q <= dcnt_q - DCW'(1);
				if (dcnt_q == DCW'(1)) begin
					dbusy_q <= 1'b0;
				end
			end else if (dfin) begin
				ph_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dstart) begin
			dq_q <= dnum;
			dr_q <= '0;
			dd_q <= dden;
		end else if (dbusy_q) begin
			if (!trial[scs_pkg::DEN_W+1]) begin
				dr_q <= trial[scs_pkg::DEN_W-1:0];
				dq_q <= {dq_q[scs_pkg::NUM_W-2:0], 1'b1};
			end else begin
				dr_q <= {dr_q[scs_pkg::DEN_W-2:0], dq_q[scs_pkg::NUM_W-1]};
				dq_q <= {dq_q[scs_pkg::NUM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_M1, ST_M2, ST_M3, ST_RMM, ST_N1, ST_N2, ST_FIN: prod_q <= mul_a * mul_b;
			default: prod_q <= prod_q;
		endcase
		if (state_q == ST_M2 || state_q == ST_N2) begin
			t_q <= prod_q;
		end
		if (state_q == ST_M3) begin
			diff_q <= t_q - prod_q;
		end
		if (state_q == ST_MCAP) begin
			cur_id_q <= rdata_q[MW-1:scs_pkg::LVL_W];
			cur_lv_q <= rdata_q[scs_pkg::LVL_W-1:0];
		end
		if (state_q == ST_CC && dfin) begin
			cc_q <= dq_q[scs_pkg::Q_W-1:0];
		end
		if (state_q == ST_SC && dfin) begin
			sc_q <= ({1'b0, match_q} > u_s)
				? -$signed({1'b0, dq_q[scs_pkg::FRAC_W+CW-1:0]})
				: $signed({1'b0, dq_q[scs_pkg::FRAC_W+CW-1:0]});
		end
		if (state_q == ST_RM) begin
			if (match_q == '0) begin
				rm_q <= '0;
			end else if (dfin) begin
				rm_q <= scs_pkg::sat_one(dq_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			use_set_q <= 1'b1;
			have_prev_q <= 1'b0;
			bank_q <= 1'b0;
			nc_q <= '0;
			np_q <= '0;
			i_q <= '0;
			j_q <= '0;
			match_q <= '0;
			mv_q <= '0;
			sumc_q <= '0;
			sump_q <= '0;
			score_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (cfg_valid) begin
				use_set_q <= cfg_data;
			end
			if (out_valid_q && !out_stall && !take_out) begin
				out_valid_q <= 1'b0;
			end
			if (rec_wr) begin
				nc_q <= nc_q + CW'(1);
				sumc_q <= sumc_q + scs_pkg::SUM_W'(in_item.rssi);
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && is_end) begin
						if (!have_prev_q || (nc_q == '0 && np_q == '0)) begin
							score_q <= '0;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_CC;
						end
					end
				end
				ST_CC: if (dfin) state_q <= ST_M1;
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: state_q <= ST_MS;
				ST_MS: begin
					if (dfin) begin
						match_q <= '0;
						mv_q <= '0;
						i_q <= '0;
						if (!use_set_q) begin
							score_q <= scs_pkg::sat_score(scs_pkg::NUM_W'(
								({1'b0, cc_q} + {1'b0, scs_pkg::sat_one(dq_q)}) >> 1));
							state_q <= ST_OUT;
						end else if (nc_q == '0 || np_q == '0) begin
							state_q <= ST_SC;
						end else begin
							state_q <= ST_MI;
						end
					end
				end
				ST_MI: begin
					if (i_q == nc_q) begin
						state_q <= ST_SC;
					end else begin
						state_q <= ST_MCAP;
					end
				end
				ST_MCAP: begin
					j_q <= '0;
					state_q <= ST_MJ;
				end
				ST_MJ: begin
					if (id_eq) begin
						match_q <= match_q + CW'(1);
						mv_q <= mv_q + MVW'(alv);
						i_q <= i_q + CW'(1);
						state_q <= ST_MI;
					end else if (last_j) begin
						i_q <= i_q + CW'(1);
						state_q <= ST_MI;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				ST_SC: if (dfin) state_q <= ST_RMM;
				ST_RMM: state_q <= ST_RM;
				ST_RM: if (match_q == '0 || dfin) state_q <= ST_N1;
				ST_N1: state_q <= ST_N2;
				ST_N2: state_q <= ST_FIN;
				ST_FIN: begin
					if (num_s <= 0) begin
						score_q <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DQ;
					end
				end
				ST_DQ: begin
					score_q <= scs_pkg::sat_score(
						scs_pkg::NUM_W'(prod_q >>> scs_pkg::RECIP_SH));
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (take_out) begin
						out_valid_q <= 1'b1;
						out_q.change_score <= score_q;
						out_q.device_count <= scs_pkg::DCNT_W'(nc_q);
						bank_q <= ~bank_q;
						np_q <= nc_q;
						sump_q <= sumc_q;
						nc_q <= '0;
						sumc_q <= '0;
						have_prev_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/scs_checker.sv */
// Port-level assertions for the scan change score unit, bound to the top level.
module scs_checker #(
	parameter int unsigned MAX_DEVICES = scs_pkg::MAX_DEVICES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input scs_pkg::in_item_t in_item,
	input logic out_valid,
	input logic out_stall,
	input scs_pkg::out_item_t out_item,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic cfg_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result transaction changed");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.device_count <= scs_pkg::DCNT_W'(MAX_DEVICES))
		else $error("device count above capacity");

	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.action == scs_pkg::ACT_END |=> in_stall)
		else $error("end of scan did not stall input");

	a_cfg_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config port not ready");

endmodule

bind scan_change_score_unit scs_checker #(.MAX_DEVICES(MAX_DEVICES)) u_scs_checker (.*);

/* test/tb.sv */
// Testbench for scan_change_score_unit: scoreboard-checked scans in both scoring modes.
class scan_scoreboard;
	bit mode_set;
	logic [47:0] prev_ids[32];
	int prev_lvls[32];
	int prev_n;
	logic [47:0] cur_ids[32];
	int cur_lvls[32];
	int cur_n;
	bit seen_scan;
	scs_pkg::out_item_t pending[$];
	int errors;

	function new();
		mode_set = 1;
		prev_n = 0;
		cur_n = 0;
		seen_scan = 0;
		errors = 0;
	endfunction

	function longint absl(longint x);
		return x < 0 ? -x : x;
	endfunction

	function longint change_score();
		longint np, nc, mx, cc, sp, sc_sum, dp, dc, ms, hits, mv, u, setc, rm, num;
		np = prev_n;
		nc = cur_n;
		sp = 0;
		sc_sum = 0;
		hits = 0;
		mv = 0;
		rm = 0;
		if (!seen_scan || (np == 0 && nc == 0))
			return 0;
		mx = nc > np ? nc : np;
		if (mx < 1)
			mx = 1;
		cc = absl(nc - np) * 65536 / mx;
		for (int i = 0; i < prev_n; i++)
			sp += prev_lvls[i];
		for (int i = 0; i < cur_n; i++)
			sc_sum += cur_lvls[i];
		dp = np ? np : 1;
		dc = nc ? nc : 1;
		ms = absl(sc_sum * dp - sp * dc) * 65536 / (dp * dc * 8);
		if (ms > 65536)
			ms = 65536;
		if (!mode_set)
			return (cc + ms) / 2;
		for (int i = 0; i < cur_n; i++)
			for (int j = 0; j < prev_n; j++)
				if (cur_ids[i] == prev_ids[j]) begin
					hits++;
					mv += absl(cur_lvls[i] - prev_lvls[j]);
					break;
				end
		u = nc + np - hits;
		setc = u > 0 ? (u - hits) * 65536 / u : 0;
		if (hits) begin
			rm = mv * 65536 / (hits * 12);
			if (rm > 65536)
				rm = 65536;
		end
		num = 35 * (cc + setc) + 30 * rm;
		if (num <= 0)
			return 0;
		return num / 100;
	endfunction

	function void note_input(scs_pkg::in_item_t it);
		longint s;
		scs_pkg::out_item_t r;
		if (it.action == scs_pkg::ACT_RECORD) begin
			if (cur_n < 32) begin
				cur_ids[cur_n] = it.device_id;
				cur_lvls[cur_n] = it.rssi;
				cur_n++;
			end
			return;
		end
		s = change_score();
		if (s < 0)
			s = 0;
		if (s > 65535)
			s = 65535;
		r.change_score = s[15:0];
		r.device_count = cur_n[5:0];
		pending.push_back(r);
		for (int i = 0; i < cur_n; i++) begin
			prev_ids[i] = cur_ids[i];
			prev_lvls[i] = cur_lvls[i];
		end
		prev_n = cur_n;
		cur_n = 0;
		seen_scan = 1;
	endfunction

	function void check_result(scs_pkg::out_item_t got);
		scs_pkg::out_item_t exp;
		if (pending.size() == 0) begin
			$display("%0t unexpected transaction: actual score %0d count %0d",
				$realtime, got.change_score, got.device_count);
			errors++;
			return;
		end
		exp = pending.pop_front();
		if (got.change_score !== exp.change_score) begin
			$display("%0t change_score mismatch: expected %0d actual %0d",
				$realtime, exp.change_score, got.change_score);
			errors++;
		end
		if (got.device_count !== exp.device_count) begin
			$display("%0t device_count mismatch: expected %0d actual %0d",
				$realtime, exp.device_count, got.device_count);
			errors++;
		end
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	scs_pkg::in_item_t in_item;
	logic out_valid;
	logic out_stall;
	scs_pkg::out_item_t out_item;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;

	int send_idle_pct;
	int recv_stall_pct;
	int sent;
	logic [47:0] pool[16];
	scan_scoreboard sb;

	scan_change_score_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(out_item);
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic send(input logic act, input logic [47:0] id, input logic [7:0] lvl);
		scs_pkg::in_item_t it;
		it.action = act;
		it.device_id = id;
		it.rssi = lvl;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_item <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(it);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		drain();
		cfg_valid <= 1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		sb.mode_set = m;
	endtask

	task automatic random_scan();
		int n;
		logic [47:0] id;
		n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(3) != 0)
				id = pool[$urandom_range(15)];
			else
				id = 48'({$urandom, $urandom});
			send(scs_pkg::ACT_RECORD, id, 8'($urandom));
		end
		send(scs_pkg::ACT_END, 48'({$urandom, $urandom}), 8'($urandom));
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		in_valid = 0;
		in_item = '0;
		out_stall = 0;
		cfg_valid = 0;
		cfg_data = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		sent = 0;
		for (int i = 0; i < 16; i++)
			pool[i] = 48'({$urandom, $urandom});
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send(scs_pkg::ACT_END, '0, '0);
		send(scs_pkg::ACT_END, '1, '1);
		send(scs_pkg::ACT_RECORD, '0, 8'h80);
		send(scs_pkg::ACT_RECORD, '1, 8'h7f);
		send(scs_pkg::ACT_END, '0, '0);
		send(scs_pkg::ACT_RECORD, '1, 8'h80);
		send(scs_pkg::ACT_RECORD, '1, 8'h80);
		send(scs_pkg::ACT_RECORD, '1, 8'h80);
		send(scs_pkg::ACT_END, '0, '0);
		for (int i = 0; i < 34; i++)
			send(scs_pkg::ACT_RECORD, 48'(i), 8'(i * 7));
		send(scs_pkg::ACT_END, '0, '0);
		write_mode(0);
		send(scs_pkg::ACT_RECORD, 48'h5, 8'h80);
		send(scs_pkg::ACT_END, '0, '0);
		send(scs_pkg::ACT_END, '0, '0);

		while (sent < 1450) begin
			case ($urandom_range(3))
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 82; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 82; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			for (int k = 0; k < 8; k++)
				random_scan();
			if ($urandom_range(2) == 0)
				write_mode(1'($urandom_range(1)));
			else
				drain();
		end
		write_mode(1);
		random_scan();
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
